/* hdl/itaf_pkg.sv */
`timescale 1ns / 1ps

package itaf_pkg;

    typedef enum logic [1:0] {
        OP_SDEC = 2'd0,
        OP_UDEC = 2'd1,
        OP_HEXL = 2'd2,
        OP_HEXU = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_CONV  = 2'd1,
        S_COUNT = 2'd2,
        S_EMIT  = 2'd3
    } t_back_state;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LOWA  = 8'h61;
    localparam logic [7:0] CH_UPA   = 8'h41;

    localparam int NARROW_BITS = 32;
    localparam int PREC_W      = 6;
    localparam int OP_W        = 2;
    localparam int CHAR_W      = 8;

endpackage

/* hdl/itaf_front.sv */
`timescale 1ns / 1ps

module itaf_front
    import itaf_pkg::*;
#(
    parameter int W = 64
) (
    input  logic [63:0]        i_value,
    input  t_opcode            i_opcode,
    input  logic               i_wide_mode,
    output logic [W-1:0]       o_mag,
    output logic               o_neg
);

    logic [W-1:0] v;
    logic [W-1:0] v_neg;
    logic         sign;

    always_comb begin
        if (i_wide_mode) begin
            v    = i_value[W-1:0];
            sign = i_value[W-1];
        end else begin
            v    = W'(i_value[NARROW_BITS-1:0]);
            sign = i_value[NARROW_BITS-1];
        end
        v_neg = W'(~v + W'(1));
        o_neg = (i_opcode == OP_SDEC) && sign;
        if (!o_neg) begin
            o_mag = v;
        end else if (i_wide_mode) begin
            o_mag = v_neg;
        end else begin
            o_mag = W'(v_neg[NARROW_BITS-1:0]);
        end
    end

endmodule

/* hdl/itaf_queue.sv */
`timescale 1ns / 1ps

module itaf_queue #(
    parameter int DATA_W = 73
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_pop_data,
    output logic              o_valid
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_cnt;
    logic              n_wr;
    logic              n_rd;
    logic [1:0]        n_cnt;
    logic              do_wr;
    logic              do_rd;

    assign o_full     = (r_cnt == 2'd2);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_pop_data = r_mem[r_rd];
    assign do_wr      = i_push && !o_full;
    assign do_rd      = i_pop && o_valid;

    always_comb begin
        n_wr  = do_wr ? ~r_wr : r_wr;
        n_rd  = do_rd ? ~r_rd : r_rd;
        n_cnt = r_cnt + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

/* hdl/itaf_back.sv */
`timescale 1ns / 1ps

module itaf_back
    import itaf_pkg::*;
#(
    parameter int W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [W-1:0]      i_mag,
    input  logic              i_neg,
    input  t_opcode           i_opcode,
    input  logic [PREC_W-1:0] i_precision,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [CHAR_W-1:0] o_tdata,
    output logic              o_tlast
);

    localparam int ND        = (W * 30103) / 100000 + 1;
    localparam int DIG_W     = ND * 4;
    localparam int STEPS     = (W + 3) / 4;
    localparam int CONV_BITS = STEPS * 4;
    localparam int STEP_W    = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int IDX_W     = $clog2(ND);
    localparam int CNT_W     = $clog2(ND + 1);

    t_back_state           r_state;
    t_back_state           n_state;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [CHAR_W-1:0]     r_out_char;
    logic [CHAR_W-1:0]     n_out_char;
    logic                  r_out_last;
    logic                  n_out_last;
    logic [DIG_W-1:0]      r_dig;
    logic [DIG_W-1:0]      n_dig;
    logic [CONV_BITS-1:0]  r_bin;
    logic [CONV_BITS-1:0]  n_bin;
    logic [STEP_W-1:0]     r_step;
    logic [STEP_W-1:0]     n_step;
    logic                  r_neg;
    logic                  n_neg;
    t_opcode               r_op;
    t_opcode               n_op;
    logic [PREC_W-1:0]     r_prec;
    logic [PREC_W-1:0]     n_prec;
    logic [PREC_W-1:0]     r_pad;
    logic [PREC_W-1:0]     n_pad;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      n_idx;
    logic                  load_ok;

    assign load_ok  = !r_out_valid || i_tready;
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_char;
    assign o_tlast  = r_out_last;

    always_comb begin
        logic [DIG_W-1:0]     bcd;
        logic [CONV_BITS-1:0] bin;
        logic [CNT_W-1:0]     nd;
        logic [3:0]           d;
        logic [CHAR_W-1:0]    alpha;

        n_state     = r_state;
        n_out_valid = r_out_valid && !i_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_dig       = r_dig;
        n_bin       = r_bin;
        n_step      = r_step;
        n_neg       = r_neg;
        n_op        = r_op;
        n_prec      = r_prec;
        n_pad       = r_pad;
        n_idx       = r_idx;
        o_pop       = 1'b0;
        bcd         = r_dig;
        bin         = r_bin;
        nd          = CNT_W'(1);
        d           = r_dig[r_idx * 4 +: 4];
        alpha       = (r_op == OP_HEXU) ? CH_UPA : CH_LOWA;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop  = 1'b1;
                    n_neg  = i_neg;
                    n_op   = i_opcode;
                    n_prec = i_precision;
                    if (i_opcode == OP_SDEC || i_opcode == OP_UDEC) begin
                        n_bin   = CONV_BITS'(i_mag);
                        n_dig   = '0;
                        n_step  = '0;
                        n_state = S_CONV;
                    end else begin
                        n_dig   = DIG_W'(i_mag);
                        n_state = S_COUNT;
                    end
                end
            end
            S_CONV: begin
                for (int b = 0; b < 4; b++) begin
                    for (int k = 0; k < ND; k++) begin
                        if (bcd[k * 4 +: 4] >= 4'd5) begin
                            bcd[k * 4 +: 4] = bcd[k * 4 +: 4] + 4'd3;
                        end
                    end
                    bcd = {bcd[DIG_W-2:0], bin[CONV_BITS-1]};
                    bin = {bin[CONV_BITS-2:0], 1'b0};
                end
                n_dig  = bcd;
                n_bin  = bin;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                for (int k = 0; k < ND; k++) begin
                    if (r_dig[k * 4 +: 4] != 4'd0) begin
                        nd = CNT_W'(k + 1);
                    end
                end
                n_idx = IDX_W'(nd - CNT_W'(1));
                if (r_op == OP_SDEC && {1'b0, r_prec} > 7'(nd)) begin
                    n_pad = PREC_W'(7'(r_prec) - 7'(nd));
                end else begin
                    n_pad = '0;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (load_ok) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b0;
                    if (r_neg) begin
                        n_out_char = CH_MINUS;
                        n_neg      = 1'b0;
                    end else if (r_pad != '0) begin
                        n_out_char = CH_ZERO;
                        n_pad      = r_pad - PREC_W'(1);
                    end else begin
                        if (d >= 4'd10) begin
                            n_out_char = alpha + CHAR_W'(d) - CHAR_W'(10);
                        end else begin
                            n_out_char = CH_ZERO + CHAR_W'(d);
                        end
                        if (r_idx == '0) begin
                            n_out_last = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            n_idx = r_idx - IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_dig      <= n_dig;
        r_bin      <= n_bin;
        r_step     <= n_step;
        r_neg      <= n_neg;
        r_op       <= n_op;
        r_prec     <= n_prec;
        r_pad      <= n_pad;
        r_idx      <= n_idx;
    end

endmodule

/* hdl/integer_to_ascii_formatter_top.sv */
`timescale 1ns / 1ps

// Channel   Dir  Payload
// s_axis    in   tdata: value[63:0], precision[69:64], zero [71:70]
//                tuser: opcode[1:0], wide_mode[2]
// m_axis    out  tdata: character[7:0]; tlast: last character of the number
//
// Decimal items are loaded, converted by double dabble four bits per step,
// then their digits are counted; one character per cycle follows while m_axis
// is ready. Hex skips the double dabble. A 64-bit decimal has up to 20 digits,
// and a padded negative up to 64 characters; an m_axis stall holds the output.
// Reset is synchronous, active low, and empties the 2-entry job queue.
// The front keeps accepting into the queue, until it is full, while the back waits on m_axis.

module integer_to_ascii_formatter_top
    import itaf_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // value[63:0], precision[69:64]
    input  logic [2:0]  i_s_axis_tuser,   // opcode[1:0], wide_mode[2]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // character[7:0]
    output logic        o_m_axis_tlast
);

    localparam int JOB_W = VALUE_BITS + 1 + OP_W + PREC_W;

    logic [VALUE_BITS-1:0] front_mag;
    logic                  front_neg;
    logic [JOB_W-1:0]      push_data;
    logic [JOB_W-1:0]      pop_data;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;
    logic                  push;

    itaf_front #(
        .W (VALUE_BITS)
    ) u_front (
        .i_value     (i_s_axis_tdata[63:0]),
        .i_opcode    (t_opcode'(i_s_axis_tuser[1:0])),
        .i_wide_mode (i_s_axis_tuser[2]),
        .o_mag       (front_mag),
        .o_neg       (front_neg)
    );

    assign push            = i_s_axis_tvalid;
    assign o_s_axis_tready = !q_full;
    assign push_data       = {i_s_axis_tdata[69:64], i_s_axis_tuser[1:0], front_neg, front_mag};

    itaf_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (pop_data),
        .o_valid     (q_valid)
    );

    itaf_back #(
        .W (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_mag       (pop_data[VALUE_BITS-1:0]),
        .i_neg       (pop_data[VALUE_BITS]),
        .i_opcode    (t_opcode'(pop_data[VALUE_BITS+1 +: OP_W])),
        .i_precision (pop_data[VALUE_BITS+1+OP_W +: PREC_W]),
        .o_pop       (q_pop),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_tdata     (o_m_axis_tdata),
        .o_tlast     (o_m_axis_tlast)
    );

endmodule
